[rtl/assert_macros.svh]
// Assertion macros used by the checker module of this block.
// Included by bare file name; has no dependencies of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, ignored while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/asfp_pkg.sv]
// Shared types and constants of the acceleration sample frame packer.
// No dependencies; imported by every RTL module of the block.
package asfp_pkg;

  // Frame geometry.
  localparam int SAMPLES_PER_FRAME_DEF = 40;
  localparam int AXIS_W                = 16;
  localparam int BYTE_W                = 8;
  localparam int IN_DATA_W             = 3 * AXIS_W;
  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h02;

  // Depth of the queue between front and back; a power of two.
  localparam int QUEUE_DEPTH = 2;

  // Byte positions within the bytes that one sample causes.
  typedef logic [3:0] step_t;
  localparam step_t STEP_HDR = 4'd0;
  localparam step_t STEP_LEN = 4'd1;
  localparam step_t STEP_XH  = 4'd2;
  localparam step_t STEP_XL  = 4'd3;
  localparam step_t STEP_YH  = 4'd4;
  localparam step_t STEP_YL  = 4'd5;
  localparam step_t STEP_ZH  = 4'd6;
  localparam step_t STEP_ZL  = 4'd7;
  localparam step_t STEP_SUM = 4'd8;

  // One classified sample as it waits in the queue.
  typedef struct packed {
    logic [AXIS_W-1:0] accel_x;
    logic [AXIS_W-1:0] accel_y;
    logic [AXIS_W-1:0] accel_z;
    logic              opens;
    logic              closes;
  } sample_entry_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[rtl/asfp_front.sv]
// Front of the frame packer: accepts samples and marks frame open/close.
// Depends on asfp_pkg.
module asfp_front #(
  parameter int SAMPLES_PER_FRAME = asfp_pkg::SAMPLES_PER_FRAME_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  input  logic [asfp_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  asfp_pkg::queue_status_t       q_status,
  output logic                          q_push,
  output asfp_pkg::sample_entry_t       q_entry
);
  import asfp_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES_PER_FRAME + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_FRAME - 1);

  logic [CNT_W-1:0] sample_count;
  logic [CNT_W-1:0] sample_count_next;
  logic             accept;
  logic             closes;

  // Accept while the queue has room.
  assign s_axis_tready = !q_status.full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign q_push        = accept;

  // Classify the sample by its place in the frame.
  assign closes = (sample_count >= CNT_LAST);
  always_comb begin
    q_entry.accel_x = s_axis_tdata[AXIS_W-1:0];
    q_entry.accel_y = s_axis_tdata[2*AXIS_W-1:AXIS_W];
    q_entry.accel_z = s_axis_tdata[3*AXIS_W-1:2*AXIS_W];
    q_entry.opens   = (sample_count == '0);
    q_entry.closes  = closes;
  end

  // Samples packed into the open frame.
  always_comb begin
    sample_count_next = sample_count;
    if (accept) begin
      sample_count_next = closes ? '0 : sample_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
    end else begin
      sample_count <= sample_count_next;
    end
  end

endmodule

[rtl/asfp_queue.sv]
// Short register queue of classified samples between front and back.
// Depends on asfp_pkg.
module asfp_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  asfp_pkg::sample_entry_t push_entry,
  input  logic                    pop,
  output asfp_pkg::sample_entry_t head,
  output asfp_pkg::queue_status_t status
);
  import asfp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

  sample_entry_t    entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (fill == DEPTH_CNT);
  assign status.empty = (fill == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[rtl/asfp_back.sv]
// Back of the frame packer: serializes one queued sample into frame bytes,
// keeps the running checksum and drives the registered output. Uses asfp_pkg.
module asfp_back #(
  parameter int SAMPLES_PER_FRAME = asfp_pkg::SAMPLES_PER_FRAME_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  asfp_pkg::queue_status_t    q_status,
  input  asfp_pkg::sample_entry_t    q_head,
  output logic                       q_pop,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // frame_byte [7:0]
  output logic [asfp_pkg::BYTE_W-1:0] m_axis_tdata,
  // last_of_run
  output logic                       m_axis_tlast,
  // frame_end [0]
  output logic [0:0]                 m_axis_tuser
);
  import asfp_pkg::*;

  localparam logic [BYTE_W-1:0] LEN_BYTE = BYTE_W'((6 * SAMPLES_PER_FRAME) % 256);

  step_t             step;
  logic              active;
  step_t             cur_step;
  logic              emit;
  logic              last_byte;
  logic [BYTE_W-1:0] cur_byte;
  logic [BYTE_W-1:0] running_sum;

  // Current byte position of the head sample.
  assign cur_step  = active ? step : (q_head.opens ? STEP_HDR : STEP_XH);
  assign emit      = !q_status.empty && (!m_axis_tvalid || m_axis_tready);
  assign last_byte = q_head.closes ? (cur_step == STEP_SUM) : (cur_step == STEP_ZL);
  assign q_pop     = emit && last_byte;

  // Byte selection by position.
  always_comb begin
    unique case (cur_step)
      STEP_HDR: cur_byte = HEADER_BYTE;
      STEP_LEN: cur_byte = LEN_BYTE;
      STEP_XH:  cur_byte = q_head.accel_x[15:8];
      STEP_XL:  cur_byte = q_head.accel_x[7:0];
      STEP_YH:  cur_byte = q_head.accel_y[15:8];
      STEP_YL:  cur_byte = q_head.accel_y[7:0];
      STEP_ZH:  cur_byte = q_head.accel_z[15:8];
      STEP_ZL:  cur_byte = q_head.accel_z[7:0];
      STEP_SUM: cur_byte = running_sum;
      default:  cur_byte = '0;
    endcase
  end

  // Position tracking and checksum.
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      step        <= STEP_HDR;
      running_sum <= '0;
    end else if (emit) begin
      active <= !last_byte;
      step   <= cur_step + 1'b1;
      priority if (cur_step == STEP_SUM) begin
        running_sum <= '0;
      end else if (cur_step == STEP_HDR) begin
        running_sum <= cur_byte;
      end else begin
        running_sum <= running_sum + cur_byte;
      end
    end
  end

  // Output register: valid control.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata    <= cur_byte;
      m_axis_tlast    <= last_byte;
      m_axis_tuser[0] <= (cur_step == STEP_SUM);
    end
  end

endmodule

[rtl/accel_sample_frame_packer_unit.sv]
// Channel   Dir  Bits  Contents
// s_axis    in   48    accel_x [15:0], accel_y [31:16], accel_z [47:32]
// m_axis    out  8+1+1 tdata frame_byte, tlast last_of_run, tuser frame_end
//
// Each sample yields 6 bytes, 8 when it opens a frame, 7 when it closes one
// and 9 when it opens and closes one; the back end sends one byte per cycle
// while a sample waits and the output is not stalled. The front end accepts
// a new sample whenever the two-entry queue has room, also while bytes are
// still leaving. Synchronous reset clears the frame count, checksum, queue
// and output valid. A stalled output holds its byte; the queue fills and then
// input stalls.
module accel_sample_frame_packer_unit #(
  parameter int SAMPLES_PER_FRAME = asfp_pkg::SAMPLES_PER_FRAME_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  input  logic [asfp_pkg::IN_DATA_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // frame_byte [7:0]
  output logic [asfp_pkg::BYTE_W-1:0]    m_axis_tdata,
  // last_of_run
  output logic                           m_axis_tlast,
  // frame_end [0]
  output logic [0:0]                     m_axis_tuser
);
  import asfp_pkg::*;

  queue_status_t q_status;
  sample_entry_t push_entry;
  sample_entry_t head_entry;
  logic          q_push;
  logic          q_pop;

  // Intake and classification.
  asfp_front #(
    .SAMPLES_PER_FRAME(SAMPLES_PER_FRAME)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .q_status     (q_status),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  // Decoupling queue.
  asfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(push_entry),
    .pop       (q_pop),
    .head      (head_entry),
    .status    (q_status)
  );

  // Byte serializer and output register.
  asfp_back #(
    .SAMPLES_PER_FRAME(SAMPLES_PER_FRAME)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .q_head       (head_entry),
    .q_pop        (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

[rtl/asfp_checker.sv]
// Port-level checks of the frame packer, bound to its top level.
// Depends on assert_macros.svh and asfp_pkg.
`include "assert_macros.svh"

module asfp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [asfp_pkg::BYTE_W-1:0] m_axis_tdata,
  input logic                        m_axis_tlast,
  input logic [0:0]                  m_axis_tuser
);
  import asfp_pkg::*;

  // A stalled output item keeps its byte and flags.
  `ASSERT_CLK(a_out_hold, clk, rst,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled output item changed")

  // The checksum byte is always the final byte of its sample.
  `ASSERT_CLK(a_end_is_last, clk, rst, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast, "frame end without last of run")

  // Reset leaves no output item pending.
  `ASSERT_ALWAYS(a_rst_clears, clk, rst |=> !m_axis_tvalid, "output valid after reset")

  // An idle output means the queue has room, so an offered item is taken.
  `ASSERT_CLK(a_idle_takes, clk, rst, s_axis_tvalid && !m_axis_tvalid |-> s_axis_tready, "input stalled while output idle")

endmodule

bind accel_sample_frame_packer_unit asfp_checker u_asfp_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);
